>>> rtl/ctse_pkg.sv
// ----------------------------------------------------------------------------
// ctse_pkg: shared types and helpers for the clock time set editor
// Event codes, field selectors, the time record and the month length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ctse_pkg;

  // Event kinds carried in the op field
  typedef enum logic [1:0] {
    OP_STEP  = 2'd0,
    OP_PRESS = 2'd1,
    OP_HOLD  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Field selector codes
  typedef enum logic [2:0] {
    FLD_HOURS   = 3'd0,
    FLD_MINUTES = 3'd1,
    FLD_SECONDS = 3'd2,
    FLD_WEEKDAY = 3'd3,
    FLD_DATE    = 3'd4,
    FLD_MONTH   = 3'd5,
    FLD_YEAR    = 3'd6
  } field_t;

  localparam logic [2:0] NUM_FIELDS = 3'd7;

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] weekday;
    logic [4:0] date;
    logic [3:0] month;
    logic [6:0] year;
  } ctse_time_t;

  typedef struct packed {
    logic [1:0] op;
    logic       step_up;
    logic [4:0] live_hours;
    logic [5:0] live_minutes;
    logic [5:0] live_seconds;
    logic [2:0] live_weekday;
    logic [4:0] live_date;
    logic [3:0] live_month;
    logic [6:0] live_year;
  } ctse_in_t;

  typedef struct packed {
    logic       editing;
    logic [2:0] selected_field;
    logic       commit;
    logic [4:0] out_hours;
    logic [5:0] out_minutes;
    logic [5:0] out_seconds;
    logic [2:0] out_weekday;
    logic [4:0] out_date;
    logic [3:0] out_month;
    logic [6:0] out_year;
  } ctse_out_t;

  // Days in a month; an invalid month counts as 31, February of a leap year as 29.
  function automatic logic [4:0] days_of(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] dim;
    begin
      case (month)
        4'd2:    dim = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
        4'd4:    dim = 5'd30;
        4'd6:    dim = 5'd30;
        4'd9:    dim = 5'd30;
        4'd11:   dim = 5'd30;
        default: dim = 5'd31;
      endcase
      return dim;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/ctse_in_if.sv
// ----------------------------------------------------------------------------
// ctse_in_if: event channel
// Valid/ready channel carrying one user event and the live time per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctse_in_if;
  logic               valid;
  logic               ready;
  ctse_pkg::ctse_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/ctse_out_if.sv
// ----------------------------------------------------------------------------
// ctse_out_if: result channel
// Valid/ready channel carrying the editor state after one event per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctse_out_if;
  logic                valid;
  logic                ready;
  ctse_pkg::ctse_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/ctse_field_step.sv
// ----------------------------------------------------------------------------
// ctse_field_step: one knob step on the selected field
// Wraps the selected field within its range and clamps the date on a month change.
// ----------------------------------------------------------------------------
`default_nettype none

module ctse_field_step (
  input  wire logic [2:0]          sel,
  input  wire logic                up,
  input  wire ctse_pkg::ctse_time_t cur,
  output ctse_pkg::ctse_time_t      nxt
);
  import ctse_pkg::*;

  logic [6:0] hr_sum;
  logic [6:0] mi_sum;
  logic [6:0] se_sum;
  logic [7:0] yr_sum;
  logic [4:0] hr_new;
  logic [5:0] mi_new;
  logic [5:0] se_new;
  logic [6:0] yr_new;
  logic [2:0] wd_new;
  logic [4:0] dt_new;
  logic [3:0] mo_new;
  logic [4:0] dim_cur;
  logic [4:0] dim_new;
  logic [5:0] dt_inc;
  logic [4:0] dt_dec;
  logic [3:0] mo_dec;

  // Modular counters: at most two subtractions of the modulus
  always_comb begin
    hr_sum = {2'b00, cur.hours} + (up ? 7'd1 : 7'd23);
    mi_sum = {1'b0, cur.minutes} + (up ? 7'd1 : 7'd59);
    se_sum = {1'b0, cur.seconds} + (up ? 7'd1 : 7'd59);
    yr_sum = {1'b0, cur.year} + (up ? 8'd1 : 8'd99);

    if (hr_sum >= 7'd48)      hr_new = 5'(hr_sum - 7'd48);
    else if (hr_sum >= 7'd24) hr_new = 5'(hr_sum - 7'd24);
    else                      hr_new = hr_sum[4:0];

    if (mi_sum >= 7'd120)     mi_new = 6'(mi_sum - 7'd120);
    else if (mi_sum >= 7'd60) mi_new = 6'(mi_sum - 7'd60);
    else                      mi_new = mi_sum[5:0];

    if (se_sum >= 7'd120)     se_new = 6'(se_sum - 7'd120);
    else if (se_sum >= 7'd60) se_new = 6'(se_sum - 7'd60);
    else                      se_new = se_sum[5:0];

    if (yr_sum >= 8'd200)      yr_new = 7'(yr_sum - 8'd200);
    else if (yr_sum >= 8'd100) yr_new = 7'(yr_sum - 8'd100);
    else                       yr_new = yr_sum[6:0];
  end

  // Weekday 1..7, date 1..month length, month 1..12
  always_comb begin
    if (up) wd_new = (cur.weekday == 3'd7) ? 3'd1 : 3'(cur.weekday + 3'd1);
    else    wd_new = (cur.weekday <= 3'd1) ? 3'd7 : 3'(cur.weekday - 3'd1);

    dim_cur = days_of(cur.month, cur.year);
    dt_inc  = {1'b0, cur.date} + 6'd1;
    dt_dec  = 5'(cur.date - 5'd1);
    if (up) begin
      dt_new = (dt_inc > {1'b0, dim_cur}) ? 5'd1 : dt_inc[4:0];
    end else if (cur.date <= 5'd1) begin
      dt_new = dim_cur;
    end else begin
      dt_new = (dt_dec > dim_cur) ? 5'd1 : dt_dec;
    end

    mo_dec = 4'(cur.month - 4'd1);
    if (up)                    mo_new = (cur.month >= 4'd12) ? 4'd1 : 4'(cur.month + 4'd1);
    else if (cur.month <= 4'd1) mo_new = 4'd12;
    else                        mo_new = (mo_dec > 4'd12) ? 4'd1 : mo_dec;
    dim_new = days_of(mo_new, cur.year);
  end

  always_comb begin
    nxt = cur;
    case (sel)
      FLD_HOURS:   nxt.hours   = hr_new;
      FLD_MINUTES: nxt.minutes = mi_new;
      FLD_SECONDS: nxt.seconds = se_new;
      FLD_WEEKDAY: nxt.weekday = wd_new;
      FLD_DATE:    nxt.date    = dt_new;
      FLD_MONTH: begin
        nxt.month = mo_new;
        if (cur.date > dim_new) nxt.date = dim_new;
      end
      FLD_YEAR:    nxt.year    = yr_new;
      default:     nxt = cur;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/clock_time_set_editor_core.sv
// ----------------------------------------------------------------------------
// clock_time_set_editor_core: knob and button editor for clock and calendar
// Takes one user event per beat and returns the edit state after that event.
// ----------------------------------------------------------------------------
// Each event beat (knob step, short press, long hold) yields exactly one
// result beat holding the edit mode flag, the selected field, a commit flag
// and the full edit copy of the time after the event. A long hold outside
// edit mode loads the live time and selects hours; in edit mode a press
// advances the field over hours, minutes, seconds, weekday, date, month,
// year; a knob step in edit mode wraps the selected field, and a month
// change clamps the date to the new month length; a hold in edit mode
// raises commit and leaves edit mode. The block takes one event every
// cycle while results are drained: state and output registers both load
// at the accepting edge, so the result shows in the cycle after. Input
// ready only drops when the output register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_time_set_editor_core (
  input  wire logic clk,
  input  wire logic rst,
  ctse_in_if.sink   evt,
  ctse_out_if.source res
);
  import ctse_pkg::*;

  // Editor state
  logic       edit_active;
  logic       edit_active_next;
  logic [2:0] edit_field;
  logic [2:0] edit_field_next;
  ctse_time_t edit_time;
  ctse_time_t edit_time_next;
  ctse_time_t step_time;
  logic       commit_next;

  // Output register
  logic       res_valid;
  ctse_out_t  res_data;

  logic       evt_acc;
  logic [3:0] field_inc;

  // Accept whenever the output register is empty or being drained this cycle
  assign evt.ready   = !res_valid || res.ready;
  assign evt_acc     = evt.valid && evt.ready;
  assign res.valid   = res_valid;
  assign res.payload = res_data;

  ctse_field_step u_step (
    .sel (edit_field),
    .up  (evt.payload.step_up),
    .cur (edit_time),
    .nxt (step_time)
  );

  // Next state for one event
  always_comb begin
    edit_active_next = edit_active;
    edit_field_next  = edit_field;
    edit_time_next   = edit_time;
    commit_next      = 1'b0;
    field_inc        = {1'b0, edit_field} + 4'd1;
    case (op_t'(evt.payload.op))
      OP_STEP: begin
        if (edit_active) edit_time_next = step_time;
      end
      OP_PRESS: begin
        // advance modulo the field count
        if (edit_active) begin
          edit_field_next = (field_inc >= {1'b0, NUM_FIELDS}) ?
                            3'(field_inc - {1'b0, NUM_FIELDS}) : field_inc[2:0];
        end
      end
      OP_HOLD: begin
        if (!edit_active) begin
          // enter edit mode with a snapshot of the live time
          edit_time_next.hours   = evt.payload.live_hours;
          edit_time_next.minutes = evt.payload.live_minutes;
          edit_time_next.seconds = evt.payload.live_seconds;
          edit_time_next.weekday = evt.payload.live_weekday;
          edit_time_next.date    = evt.payload.live_date;
          edit_time_next.month   = evt.payload.live_month;
          edit_time_next.year    = evt.payload.live_year;
          edit_field_next        = FLD_HOURS;
          edit_active_next       = 1'b1;
        end else begin
          // commit and drop out of edit mode, keep the edit copy
          commit_next      = 1'b1;
          edit_active_next = 1'b0;
          edit_field_next  = FLD_HOURS;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edit_active <= 1'b0;
      edit_field  <= FLD_HOURS;
      edit_time   <= '0;
    end else if (evt_acc) begin
      edit_active <= edit_active_next;
      edit_field  <= edit_field_next;
      edit_time   <= edit_time_next;
    end
  end

  // Output register: load on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (evt_acc) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_acc) begin
      res_data.editing        <= edit_active_next;
      res_data.selected_field <= edit_field_next;
      res_data.commit         <= commit_next;
      res_data.out_hours      <= edit_time_next.hours;
      res_data.out_minutes    <= edit_time_next.minutes;
      res_data.out_seconds    <= edit_time_next.seconds;
      res_data.out_weekday    <= edit_time_next.weekday;
      res_data.out_date       <= edit_time_next.date;
      res_data.out_month      <= edit_time_next.month;
      res_data.out_year       <= edit_time_next.year;
    end
  end

  // Outside edit mode the selector rests on hours
  a_idle_field : assert property (@(posedge clk) disable iff (rst)
    !edit_active |-> (edit_field == FLD_HOURS))
    else $error("selector not at hours outside edit mode");

  // A hold outside edit mode enters edit mode
  a_enter : assert property (@(posedge clk) disable iff (rst)
    (evt_acc && (evt.payload.op == OP_HOLD) && !edit_active) |=> edit_active)
    else $error("hold did not enter edit mode");

  // Knob steps outside edit mode leave the edit copy alone
  a_idle_step : assert property (@(posedge clk) disable iff (rst)
    (evt_acc && (evt.payload.op == OP_STEP) && !edit_active) |=> $stable(edit_time))
    else $error("edit copy changed outside edit mode");

  // Every accepted event shows up as a result beat
  a_result : assert property (@(posedge clk) disable iff (rst)
    evt_acc |=> (res_valid && (res_data.editing == edit_active)))
    else $error("result beat missing or out of step with state");

  // A commit always leaves edit mode
  a_commit : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.commit) |-> !res_data.editing)
    else $error("commit while still editing");

endmodule

`default_nettype wire
